FILE: hw/rtl/tat_pkg.sv
// Shared types, constants and the CORDIC angle table for the tilt angle block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tat_pkg;

    // Input sample and result widths.
    localparam int unsigned ACC_W   = 16;
    localparam int unsigned ANGLE_W = 15;
    localparam int unsigned SUM_W   = 2 * ACC_W;

    // Number of angle lanes: roll, pitch and elevation.
    localparam int unsigned LANES = 3;

    // Square root of the squares sum with eight fraction bits: one root bit per step.
    localparam int unsigned SQ_STEPS = (SUM_W + 16) / 2;
    localparam int unsigned RADIX_W  = SUM_W + 16;
    localparam int unsigned REM_W    = SQ_STEPS + 2;

    // CORDIC vectoring stages, at most the length of the angle table.
    localparam int unsigned CORDIC_STAGES = 16;
    localparam int unsigned CW            = 27;
    localparam int unsigned ZW            = 25;

    // Right angle in degrees scaled by 128.
    localparam int RIGHT_ANGLE = 11520;

    // Depth of the queue between front and back.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QA_W   = $clog2(QDEPTH);
    localparam int unsigned QC_W   = $clog2(QDEPTH + 1);

    // One classified sample: the numerator and squares sum of each lane.
    typedef struct packed {
        logic [LANES-1:0][ACC_W-1:0] num;
        logic [LANES-1:0][SUM_W-1:0] sum;
    } t_job;

    // Queue status seen by the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // atan(2^-i) in degrees scaled by 2^16, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:       v = 25'sd2949120;
            1:       v = 25'sd1740967;
            2:       v = 25'sd919879;
            3:       v = 25'sd466945;
            4:       v = 25'sd234379;
            5:       v = 25'sd117304;
            6:       v = 25'sd58666;
            7:       v = 25'sd29335;
            8:       v = 25'sd14668;
            9:       v = 25'sd7334;
            10:      v = 25'sd3667;
            11:      v = 25'sd1833;
            12:      v = 25'sd917;
            13:      v = 25'sd458;
            14:      v = 25'sd229;
            15:      v = 25'sd115;
            16:      v = 25'sd57;
            17:      v = 25'sd29;
            18:      v = 25'sd14;
            19:      v = 25'sd7;
            20:      v = 25'sd4;
            21:      v = 25'sd2;
            22:      v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tat_front.sv
// Front end: takes a sample, forms each lane's numerator and squares sum.
// Depends on tat_pkg; feeds tat_fifo.
`default_nettype none

module tat_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [tat_pkg::ACC_W-1:0] i_accel_x,
    input  wire logic signed [tat_pkg::ACC_W-1:0] i_accel_y,
    input  wire logic signed [tat_pkg::ACC_W-1:0] i_accel_z,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output tat_pkg::t_job                     o_job
);
    import tat_pkg::*;

    logic                    r_fv;
    logic signed [ACC_W-1:0] r_x, r_y, r_z;
    logic        [SUM_W-1:0] sq_x, sq_y, sq_z;
    logic                    load;

    // The stage refills whenever its sample has moved on or it is empty.
    assign load    = !r_fv || !i_q_full;
    assign o_stall = !load;
    assign o_push  = r_fv && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (load) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_x <= i_accel_x;
            r_y <= i_accel_y;
            r_z <= i_accel_z;
        end
    end

    // Squares are exact; the sum of two is at most 2^31.
    assign sq_x = SUM_W'(r_x * r_x);
    assign sq_y = SUM_W'(r_y * r_y);
    assign sq_z = SUM_W'(r_z * r_z);

    // Roll, pitch and elevation lanes.
    always_comb begin
        o_job.num[0] = r_y;
        o_job.sum[0] = sq_x + sq_z;
        o_job.num[1] = r_x;
        o_job.sum[1] = sq_y + sq_z;
        o_job.num[2] = r_z;
        o_job.sum[2] = sq_x + sq_y;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tat_fifo.sv
// Short flop-based queue between the front end and the arithmetic back end.
// Depends on tat_pkg for the job type and depth.
`default_nettype none

module tat_fifo (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  tat_pkg::t_job i_job,
    input  wire logic     i_pop,
    output tat_pkg::t_job o_job,
    output tat_pkg::t_qstat o_stat
);
    import tat_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QC_W-1:0] r_cnt;
    logic            do_pop;

    assign o_stat.full  = (r_cnt == QC_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tat_lane.sv
// One angle lane: pipelined square root, then pipelined CORDIC vectoring.
// Depends on tat_pkg; all stages advance together on the shared enable.
`default_nettype none

module tat_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [tat_pkg::ACC_W-1:0]      i_num,
    input  wire logic [tat_pkg::SUM_W-1:0]      i_sum,
    output logic signed [tat_pkg::ANGLE_W-1:0]  o_angle
);
    import tat_pkg::*;

    // Square root rows: row 0 is loaded from the queue, row k+1 after step k.
    logic [RADIX_W-1:0]  r_n    [SQ_STEPS+1];
    logic [REM_W-1:0]    r_rem  [SQ_STEPS+1];
    logic [SQ_STEPS-1:0] r_root [SQ_STEPS+1];
    logic [ACC_W-1:0]    r_snum [SQ_STEPS+1];
    logic                r_szero[SQ_STEPS+1];

    // CORDIC rows, 1 to CORDIC_STAGES.
    logic signed [CW-1:0] r_cx   [1:CORDIC_STAGES];
    logic signed [CW-1:0] r_cy   [1:CORDIC_STAGES];
    logic signed [ZW-1:0] r_cz   [1:CORDIC_STAGES];
    logic [ACC_W-1:0]     r_cnum [1:CORDIC_STAGES];
    logic                 r_czero[1:CORDIC_STAGES];

    logic signed [CW-1:0] c_x0, c_y0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]     <= {i_sum, 16'd0};
            r_rem[0]   <= '0;
            r_root[0]  <= '0;
            r_snum[0]  <= i_num;
            r_szero[0] <= (i_sum == '0);
        end
    end

    // Restoring square root, one root bit per stage.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [REM_W+1:0] rem2, trial;
        assign rem2  = {r_rem[k], r_n[k][RADIX_W-1 -: 2]};
        assign trial = (REM_W+2)'({r_root[k], 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]     <= {r_n[k][RADIX_W-3:0], 2'b00};
                r_snum[k+1]  <= r_snum[k];
                r_szero[k+1] <= r_szero[k];
                if (rem2 >= trial) begin
                    r_rem[k+1]  <= REM_W'(rem2 - trial);
                    r_root[k+1] <= {r_root[k][SQ_STEPS-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= REM_W'(rem2);
                    r_root[k+1] <= {r_root[k][SQ_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    // CORDIC start: x is the root, y the numerator with eight fraction bits.
    assign c_x0 = CW'(r_root[SQ_STEPS]);
    assign c_y0 = CW'({{(CW-ACC_W-8){r_snum[SQ_STEPS][ACC_W-1]}},
                       r_snum[SQ_STEPS], 8'd0});

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        logic signed [CW-1:0] x_in, y_in;
        logic signed [ZW-1:0] z_in;
        logic [ACC_W-1:0]     num_in;
        logic                 zero_in;

        if (i == 0) begin : g_first
            assign x_in    = c_x0;
            assign y_in    = c_y0;
            assign z_in    = '0;
            assign num_in  = r_snum[SQ_STEPS];
            assign zero_in = r_szero[SQ_STEPS];
        end else begin : g_next
            assign x_in    = r_cx[i];
            assign y_in    = r_cy[i];
            assign z_in    = r_cz[i];
            assign num_in  = r_cnum[i];
            assign zero_in = r_czero[i];
        end

        // Rotate towards y = 0, accumulating the angle.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cnum[i+1]  <= num_in;
                r_czero[i+1] <= zero_in;
                if (!y_in[CW-1]) begin
                    r_cx[i+1] <= x_in + (y_in >>> i);
                    r_cy[i+1] <= y_in - (x_in >>> i);
                    r_cz[i+1] <= z_in + atan_q16(i);
                end else begin
                    r_cx[i+1] <= x_in - (y_in >>> i);
                    r_cy[i+1] <= y_in + (x_in >>> i);
                    r_cz[i+1] <= z_in - atan_q16(i);
                end
            end
        end
    end

    // Round to degrees times 128, saturate and handle the degenerate cases.
    logic signed [ZW:0]   z_rnd;
    logic signed [ZW-9:0] z_deg;
    logic [ACC_W-1:0]     num_end;

    assign num_end = r_cnum[CORDIC_STAGES];
    assign z_rnd   = (ZW+1)'(r_cz[CORDIC_STAGES]) + (ZW+1)'(256);
    assign z_deg   = z_rnd[ZW:9];

    always_comb begin
        priority if (num_end == '0) begin
            o_angle = '0;
        end else if (r_czero[CORDIC_STAGES]) begin
            o_angle = num_end[ACC_W-1] ? ANGLE_W'(-RIGHT_ANGLE) : ANGLE_W'(RIGHT_ANGLE);
        end else if (z_deg > (ZW-8)'(RIGHT_ANGLE)) begin
            o_angle = ANGLE_W'(RIGHT_ANGLE);
        end else if (z_deg < -(ZW-8)'(RIGHT_ANGLE)) begin
            o_angle = ANGLE_W'(-RIGHT_ANGLE);
        end else begin
            o_angle = ANGLE_W'(z_deg);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tat_back.sv
// Back end: three angle lanes, the valid chain and the output register.
// Depends on tat_pkg and tat_lane; pops jobs from tat_fifo.
`default_nettype none

module tat_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  tat_pkg::t_job                      i_job,
    input  wire logic                          i_q_empty,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [tat_pkg::ANGLE_W-1:0] o_roll_angle,
    output logic signed [tat_pkg::ANGLE_W-1:0] o_pitch_angle,
    output logic signed [tat_pkg::ANGLE_W-1:0] o_elevation_angle
);
    import tat_pkg::*;

    localparam int unsigned DEPTH = SQ_STEPS + 1 + CORDIC_STAGES;

    logic                      en;
    logic [DEPTH-1:0]          r_v;
    logic                      r_ov;
    logic signed [ANGLE_W-1:0] lane_angle [LANES];

    // The whole pipeline moves whenever the output register can take a result.
    assign en    = !r_ov || !i_stall;
    assign o_pop = en && !i_q_empty;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        tat_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_num   (i_job.num[l]),
            .i_sum   (i_job.sum[l]),
            .o_angle (lane_angle[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[DEPTH-2:0], !i_q_empty};
            r_ov <= r_v[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_roll_angle      <= lane_angle[0];
            o_pitch_angle     <= lane_angle[1];
            o_elevation_angle <= lane_angle[2];
        end
    end

    assign o_valid = r_ov;

endmodule

`default_nettype wire

FILE: hw/rtl/accel_tilt_angles.sv
// Top level of the accelerometer tilt angle block.
// Depends on tat_pkg, tat_front, tat_fifo and tat_back.
`default_nettype none

// Each transaction carries one three-axis sample of raw counts and returns roll, pitch
// and elevation in degrees scaled by 128, rounded to nearest. A new sample is taken
// every cycle when the output side is not stalling. On its way to the result a sample
// passes one front stage, the queue, one lane input stage, 24 square root stages, 16
// CORDIC stages and the output register. A four-entry queue lets the front keep taking
// samples while the output is stalled, until the queue is full.
module accel_tilt_angles (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [tat_pkg::ACC_W-1:0] i_accel_x,
    input  wire logic signed [tat_pkg::ACC_W-1:0] i_accel_y,
    input  wire logic signed [tat_pkg::ACC_W-1:0] i_accel_z,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [tat_pkg::ANGLE_W-1:0] o_roll_angle,
    output logic signed [tat_pkg::ANGLE_W-1:0] o_pitch_angle,
    output logic signed [tat_pkg::ANGLE_W-1:0] o_elevation_angle
);
    import tat_pkg::*;

    t_job   push_job, head_job;
    t_qstat qstat;
    logic   push, pop;

    tat_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_accel_x (i_accel_x),
        .i_accel_y (i_accel_y),
        .i_accel_z (i_accel_z),
        .i_q_full  (qstat.full),
        .o_push    (push),
        .o_job     (push_job)
    );

    tat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    tat_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (head_job),
        .i_q_empty         (qstat.empty),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_roll_angle      (o_roll_angle),
        .o_pitch_angle     (o_pitch_angle),
        .o_elevation_angle (o_elevation_angle)
    );

    // Results stay within a right angle either way.
    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle >= -15'sd11520 && o_roll_angle <= 15'sd11520))
        else $error("roll angle out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle >= -15'sd11520 && o_pitch_angle <= 15'sd11520))
        else $error("pitch angle out of range");

    a_elev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elevation_angle >= -15'sd11520 && o_elevation_angle <= 15'sd11520))
        else $error("elevation angle out of range");

    // The queue can never report full and empty together.
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty at once");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the accelerometer tilt angle block.
// Depends on tat_pkg and accel_tilt_angles; it predicts each angle with its own CORDIC.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tat_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    // Expected angles of one sample.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] elev;
    } t_angles;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [ACC_W-1:0]    i_accel_x = '0;
    logic signed [ACC_W-1:0]    i_accel_y = '0;
    logic signed [ACC_W-1:0]    i_accel_z = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b1;
    logic signed [ANGLE_W-1:0]  o_roll_angle;
    logic signed [ANGLE_W-1:0]  o_pitch_angle;
    logic signed [ANGLE_W-1:0]  o_elevation_angle;

    t_angles   pending_angles[$];
    int        error_count  = 0;
    int        sample_count = 0;
    int        result_count = 0;
    int        idle_count   = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_off_cycles = 0;

    // atan(2^-i) in degrees times 2^16.
    int atan_table[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};

    accel_tilt_angles i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_accel_x         (i_accel_x),
        .i_accel_y         (i_accel_y),
        .i_accel_z         (i_accel_z),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_roll_angle      (o_roll_angle),
        .o_pitch_angle     (o_pitch_angle),
        .o_elevation_angle (o_elevation_angle)
    );

    always #5 i_clk = ~i_clk;

    // Floor shift for signed values.
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    // Integer square root of a 48-bit value, bit by bit.
    function automatic longint root_of(input longint n);
        longint rem_v;
        longint root_v;
        longint bit_v;
        rem_v  = n;
        root_v = 0;
        bit_v  = 64'sd1 <<< 62;
        while (bit_v > rem_v) bit_v = bit_v >>> 2;
        while (bit_v != 0) begin
            if (rem_v >= root_v + bit_v) begin
                rem_v  = rem_v - (root_v + bit_v);
                root_v = (root_v >>> 1) + bit_v;
            end else begin
                root_v = root_v >>> 1;
            end
            bit_v = bit_v >>> 2;
        end
        return root_v;
    endfunction

    // Angle of num against the root of a*a + b*b, degrees times 128.
    function automatic logic signed [ANGLE_W-1:0] tilt_angle(input longint num,
                                                             input longint a,
                                                             input longint b);
        longint sum_sq;
        longint cx;
        longint cy;
        longint cz;
        longint xs;
        longint ys;
        longint r;
        sum_sq = a * a + b * b;
        if (num == 0) return '0;
        if (sum_sq == 0) begin
            return (num > 0) ? ANGLE_W'(RIGHT_ANGLE) : ANGLE_W'(-RIGHT_ANGLE);
        end
        cx = root_of(sum_sq <<< 16);
        cy = num * 256;
        cz = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            xs = floor_shift(cx, i);
            ys = floor_shift(cy, i);
            if (cy >= 0) begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + longint'(atan_table[i]);
            end else begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - longint'(atan_table[i]);
            end
        end
        r = floor_shift(cz + 256, 9);
        if (r > RIGHT_ANGLE) r = RIGHT_ANGLE;
        if (r < -RIGHT_ANGLE) r = -RIGHT_ANGLE;
        return r[ANGLE_W-1:0];
    endfunction

    // Sends one sample, with a random gap before it, and records its expected angles.
    // Valid stays high on return so that the next sample can follow with no gap.
    task automatic send_sample(input logic [ACC_W-1:0] x, input logic [ACC_W-1:0] y,
                               input logic [ACC_W-1:0] z);
        t_angles exp_a;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= x;
        i_accel_y <= y;
        i_accel_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        exp_a.roll  = tilt_angle(longint'($signed(y)), longint'($signed(x)),
                                 longint'($signed(z)));
        exp_a.pitch = tilt_angle(longint'($signed(x)), longint'($signed(y)),
                                 longint'($signed(z)));
        exp_a.elev  = tilt_angle(longint'($signed(z)), longint'($signed(x)),
                                 longint'($signed(y)));
        pending_angles.push_back(exp_a);
        sample_count++;
        @(negedge i_clk);
    endtask

    // Receiver stall: random, or held high for a counted stretch.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        t_angles exp_a;
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $realtime);
            $display("FAIL accel_tilt_angles");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            result_count <= result_count + 1;
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected result roll %0d pitch %0d elevation %0d",
                         $realtime, o_roll_angle, o_pitch_angle, o_elevation_angle);
                error_count <= error_count + 1;
            end else begin
                exp_a = pending_angles.pop_front();
                if (exp_a.roll !== o_roll_angle || exp_a.pitch !== o_pitch_angle ||
                    exp_a.elev !== o_elevation_angle) begin
                    $display("%0t: expected roll %0d pitch %0d elevation %0d, got %0d %0d %0d",
                             $realtime, exp_a.roll, exp_a.pitch, exp_a.elev,
                             o_roll_angle, o_pitch_angle, o_elevation_angle);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // Axis extremes, zero axes and the zero denominator cases.
    task automatic test_directed();
        logic [ACC_W-1:0] vals[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
        send_sample('0, '0, '0);
        send_sample(16'h7fff, '0, '0);
        send_sample(16'h8000, '0, '0);
        send_sample('0, 16'h7fff, '0);
        send_sample('0, 16'h8000, '0);
        send_sample('0, '0, 16'h7fff);
        send_sample('0, '0, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample('0, '0, 16'd16384);
        for (int i = 0; i < 5; i++)
            send_sample(vals[i], vals[(i + 1) % 5], vals[(i + 3) % 5]);
        send_sample(16'h5555, 16'haaaa, 16'h1234);
        send_sample(16'haaaa, 16'h5555, 16'hedcb);
    endtask

    // Random samples: half in a realistic gravity range, a quarter full range and a quarter small ones.
    task automatic test_random(input int count);
        logic [ACC_W-1:0] a[3];
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(3))
                    0:       a[k] = ACC_W'($urandom);
                    1:       a[k] = ACC_W'($urandom_range(16) - 8);
                    default: a[k] = ACC_W'($urandom_range(32768) - 16384);
                endcase
            end
            send_sample(a[0], a[1], a[2]);
        end
    endtask

    // Long receiver hold-off while samples keep coming, to fill the pipeline.
    task automatic test_backpressure();
        hold_off_cycles = 200;
        test_random(80);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 34;
        recv_idle_pct = 50;
        test_directed();
        test_random(450);
        send_idle_pct = 50;
        recv_idle_pct = 34;
        test_random(450);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        wait_drain();
        $display("Sent %0d samples, checked %0d results across extremes, zero axes,",
                 sample_count, result_count);
        $display("random tilt and a long output hold-off.");
        if (error_count == 0 && pending_angles.size() == 0) begin
            $display("PASS accel_tilt_angles");
        end else begin
            $display("FAIL accel_tilt_angles");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: accel_tilt_angles.f
hw/rtl/tat_pkg.sv
hw/rtl/tat_front.sv
hw/rtl/tat_fifo.sv
hw/rtl/tat_lane.sv
hw/rtl/tat_back.sv
hw/rtl/accel_tilt_angles.sv
tb/sv/tb_top.sv
